// ===== rtl/particle_motion_step_defines.svh =====
// Assertion macros shared by the particle motion step RTL.
`ifndef PARTICLE_MOTION_STEP_DEFINES_SVH
`define PARTICLE_MOTION_STEP_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define PMS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pipeline check failed");

// Next-cycle implication, checked on every clock outside reset.
`define PMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pipeline check failed");

`endif

// ===== rtl/pms_pkg.sv =====
// Package with types, register codes and helpers of the particle motion step.
package pms_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [31:0] s32_t;
  typedef logic signed [32:0] s33_t;
  typedef logic signed [33:0] s34_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAVITY  = 3'd0,
    CFG_DRAG     = 3'd1,
    CFG_DT       = 3'd2,
    CFG_WIND_X   = 3'd3,
    CFG_WIND_Y   = 3'd4,
    CFG_WIND_Z   = 3'd5,
    CFG_WIND_DUR = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    s32_t        gravity_accel;
    logic [31:0] drag_coeff;
    logic [15:0] frame_delta;
    s32_t        wind_x;
    s32_t        wind_y;
    s32_t        wind_z;
    logic [31:0] wind_duration;
  } cfg_t;

  typedef struct packed {
    s32_t        pos_x;
    s32_t        pos_y;
    s32_t        pos_z;
    s32_t        vel_x;
    s32_t        vel_y;
    s32_t        vel_z;
    logic [31:0] age_us;
    logic [31:0] life_us;
  } particle_t;

  typedef struct packed {
    s32_t new_pos_x;
    s32_t new_pos_y;
    s32_t new_pos_z;
    s32_t new_vel_x;
    s32_t new_vel_y;
    s32_t new_vel_z;
    logic alive;
  } result_t;

  // Per-stage advance enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pms_en_t;

  // Hand-off between the front and back halves of the pipe
  typedef struct packed {
    s32_t [2:0] pos;
    s34_t [2:0] vsum;
    s32_t [2:0] vg;
    s32_t       factor;
    s33_t [2:0] wterm;
    logic       alive;
  } mid_t;

  // Clamp to the signed 32-bit range
  function automatic s32_t sat32(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (x > hi) begin
      return 32'sh7fffffff;
    end else if (x < lo) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

// ===== rtl/pms_cfg_regs.sv =====
// Configuration register file of the particle motion step.
module pms_cfg_regs
  import pms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (cfg_reg_e'(wr_index))
        CFG_GRAVITY:  cfg.gravity_accel <= wr_data;
        CFG_DRAG:     cfg.drag_coeff    <= wr_data;
        CFG_DT:       cfg.frame_delta   <= wr_data[15:0];
        CFG_WIND_X:   cfg.wind_x        <= wr_data;
        CFG_WIND_Y:   cfg.wind_y        <= wr_data;
        CFG_WIND_Z:   cfg.wind_z        <= wr_data;
        CFG_WIND_DUR: cfg.wind_duration <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/pms_front.sv =====
// Front half of the pipe: dt products, rounding, drag factor, gravity step.
module pms_front
  import pms_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic      clk,
  input  pms_en_t   en,
  input  cfg_t      cfg,
  input  particle_t particle,
  output mid_t      mid
);

  localparam logic signed [34:0] ONE = 35'sd1 <<< FRAC_BITS;

  typedef struct packed {
    s32_t [2:0]               pos;
    s32_t [2:0]               vel;
    logic signed [49:0]       gprod;
    logic [47:0]              dprod;
    logic signed [2:0][48:0]  wprod;
    logic                     alive;
    logic                     windy;
  } st1_t;

  st1_t st1;
  st1_t st1_next;
  mid_t mid_next;

  logic signed [32:0] acc_y;
  logic signed [16:0] dt17;
  s32_t [2:0]         wind;

  logic signed [49:0] g_half_sum;
  logic signed [49:0] g_full_sum;
  logic signed [32:0] half;
  logic signed [33:0] gdt;
  logic [48:0]        drag_sum;
  logic [32:0]        drag_dt;
  logic signed [34:0] fdiff;
  logic signed [48:0] wsum [3];

  // Stage 1: products with dt and age compares
  always_comb begin
    acc_y = -$signed({cfg.gravity_accel[31], cfg.gravity_accel});
    dt17  = $signed({1'b0, cfg.frame_delta});
    wind[0] = cfg.wind_x;
    wind[1] = cfg.wind_y;
    wind[2] = cfg.wind_z;
    st1_next.pos[0] = particle.pos_x;
    st1_next.pos[1] = particle.pos_y;
    st1_next.pos[2] = particle.pos_z;
    st1_next.vel[0] = particle.vel_x;
    st1_next.vel[1] = particle.vel_y;
    st1_next.vel[2] = particle.vel_z;
    st1_next.gprod = 50'(acc_y) * 50'(dt17);
    st1_next.dprod = 48'(cfg.drag_coeff) * 48'(cfg.frame_delta);
    for (int i = 0; i < 3; i++) begin
      st1_next.wprod[i] = 49'($signed(wind[i])) * 49'(dt17);
    end
    st1_next.alive = particle.age_us <= particle.life_us;
    st1_next.windy = particle.age_us < cfg.wind_duration;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      st1 <= st1_next;
    end
  end

  // Stage 2: round to nearest (ties up), drag factor, gravity velocity step
  always_comb begin
    g_half_sum = st1.gprod + 50'sd65536;
    g_full_sum = st1.gprod + 50'sd32768;
    half = g_half_sum[49:17];
    gdt  = g_full_sum[49:16];
    drag_sum = {1'b0, st1.dprod} + 49'd32768;
    drag_dt  = drag_sum[48:16];
    fdiff = ONE - $signed({2'b00, drag_dt});
    mid_next.factor = sat32(64'(fdiff));
    mid_next.alive  = st1.alive;
    for (int i = 0; i < 3; i++) begin
      wsum[i] = st1.wprod[i] + 49'sd32768;
      mid_next.wterm[i] = st1.windy ? $signed(wsum[i][48:16]) : 33'sd0;
      mid_next.pos[i] = st1.pos[i];
      if (i == 1) begin
        mid_next.vsum[i] = 34'($signed(st1.vel[i])) + 34'(half);
        mid_next.vg[i]   = sat32(64'($signed(st1.vel[i])) + 64'(gdt));
      end else begin
        mid_next.vsum[i] = 34'($signed(st1.vel[i]));
        mid_next.vg[i]   = st1.vel[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      mid <= mid_next;
    end
  end

endmodule

// ===== rtl/pms_back.sv =====
// Back half of the pipe: step and drag products, final sums and saturation.
module pms_back
  import pms_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic    clk,
  input  pms_en_t en,
  input  cfg_t    cfg,
  input  mid_t    mid,
  output result_t result
);

  localparam logic signed [63:0] VEL_HALF = 64'sd1 <<< (FRAC_BITS - 1);

  typedef struct packed {
    s32_t [2:0]              pos;
    logic signed [2:0][50:0] mprod;
    logic signed [2:0][63:0] vprod;
    s33_t [2:0]              wterm;
    logic                    alive;
  } st3_t;

  st3_t    st3;
  st3_t    st3_next;
  result_t result_next;

  logic signed [16:0] dt17;
  logic signed [50:0] msum [3];
  logic signed [37:0] np   [3];
  logic signed [63:0] vsum [3];
  s32_t               npos [3];
  s32_t               nvel [3];

  // Stage 3: displacement and drag multiplies
  always_comb begin
    dt17 = $signed({1'b0, cfg.frame_delta});
    st3_next.alive = mid.alive;
    for (int i = 0; i < 3; i++) begin
      st3_next.pos[i]   = mid.pos[i];
      st3_next.wterm[i] = mid.wterm[i];
      st3_next.mprod[i] = 51'($signed(mid.vsum[i])) * 51'(dt17);
      st3_next.vprod[i] = 64'($signed(mid.vg[i])) * 64'($signed(mid.factor));
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      st3 <= st3_next;
    end
  end

  // Stage 4: round, sum exactly, saturate; expired particles read as zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      msum[i] = st3.mprod[i] + 51'sd32768;
      np[i] = 38'($signed(st3.pos[i])) + 38'($signed(msum[i][50:16]))
            - 38'($signed(st3.wterm[i]));
      npos[i] = sat32(64'(np[i]));
      vsum[i] = st3.vprod[i] + VEL_HALF;
      nvel[i] = sat32(vsum[i] >>> FRAC_BITS);
    end
    if (st3.alive) begin
      result_next.new_pos_x = npos[0];
      result_next.new_pos_y = npos[1];
      result_next.new_pos_z = npos[2];
      result_next.new_vel_x = nvel[0];
      result_next.new_vel_y = nvel[1];
      result_next.new_vel_z = nvel[2];
      result_next.alive     = 1'b1;
    end else begin
      result_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      result <= result_next;
    end
  end

endmodule

// ===== rtl/particle_motion_step.sv =====
// Top level of the particle motion step: config port, stage control, datapath.
//
//  channel    | handshake                     | payload
//  -----------+-------------------------------+----------------------------
//  particle   | particle_valid / particle_stall | particle_t, one particle
//  result     | result_valid / result_stall   | result_t, one result
//  cfg        | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// Four register stages; one particle is accepted every cycle when not
// stalled. The depth is set by the two multiplier rows (dt products, then
// displacement and drag products) each followed by a rounding stage.
// A stall on the result side holds the output stage; earlier stages keep
// advancing into empty slots, so bubbles collapse before particle_stall rises.
// rst is synchronous and clears the stage valid bits and the config registers.
module particle_motion_step
  import pms_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  particle_valid,
  output logic                  particle_stall,
  input  particle_t             particle,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "particle_motion_step_defines.svh"

  cfg_t    cfg;
  pms_en_t en;
  mid_t    mid;
  logic    v1, v2, v3, v4;

  assign cfg_ready = 1'b1;

  pms_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // A stage advances when it is empty or the one after it advances
  always_comb begin
    en.s4 = !v4 || !result_stall;
    en.s3 = !v3 || en.s4;
    en.s2 = !v2 || en.s3;
    en.s1 = !v1 || en.s2;
  end

  assign particle_stall = !en.s1;
  assign result_valid   = v4;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en.s1) begin
        v1 <= particle_valid;
      end
      if (en.s2) begin
        v2 <= v1;
      end
      if (en.s3) begin
        v3 <= v2;
      end
      if (en.s4) begin
        v4 <= v3;
      end
    end
  end

  pms_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .en       (en),
    .cfg      (cfg),
    .particle (particle),
    .mid      (mid)
  );

  pms_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk    (clk),
    .en     (en),
    .cfg    (cfg),
    .mid    (mid),
    .result (result)
  );

  // An accepted particle lands in the first stage
  `PMS_ASSERT_NEXT(a_accept_fills_s1, particle_valid && !particle_stall, v1)
  // An empty pipe never pushes back
  `PMS_ASSERT_NOW(a_empty_no_stall, !v1 && !v2 && !v3 && !v4, !particle_stall)
  // Input stalls only when every stage is full and the output is held
  `PMS_ASSERT_NOW(a_stall_only_full, particle_stall,
                  v1 && v2 && v3 && v4 && result_stall)
  // Expired particles carry all-zero motion fields
  `PMS_ASSERT_NOW(a_expired_zero, result_valid && !result.alive,
                  result.new_pos_x == 0 && result.new_pos_y == 0 &&
                  result.new_pos_z == 0 && result.new_vel_x == 0 &&
                  result.new_vel_y == 0 && result.new_vel_z == 0)

endmodule

// ===== dv/motion_check_pkg.sv =====
// Scoreboard class for the particle motion step testbench: motion predictor and result check.
package motion_check_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import pms_pkg::*;

  localparam int Q_FRAC = 16;
  localparam int DT_FRAC = 16;
  localparam int MAX_PRINTED = 40;

  class motion_checker;
    cfg_t    settings;
    result_t pending_moves[$];
    int      mismatches;

    function new();
      settings = '0;
      mismatches = 0;
    endfunction

    // Shadow copy of the config registers
    function void write_reg(cfg_reg_e idx, logic [31:0] data);
      case (idx)
        CFG_GRAVITY:  settings.gravity_accel = data;
        CFG_DRAG:     settings.drag_coeff = data;
        CFG_DT:       settings.frame_delta = data[15:0];
        CFG_WIND_X:   settings.wind_x = data;
        CFG_WIND_Y:   settings.wind_y = data;
        CFG_WIND_Z:   settings.wind_z = data;
        CFG_WIND_DUR: settings.wind_duration = data;
        default: ;
      endcase
    endfunction

    // Divide by 2^s, round to nearest, ties toward +inf
    static function longint round_shift(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    static function longint clamp32(longint x);
      if (x > longint'(32'sh7fffffff)) return longint'(32'sh7fffffff);
      if (x < longint'(32'sh80000000)) return longint'(32'sh80000000);
      return x;
    endfunction

    // One frame of gravity, drag and wind for one particle
    function result_t advance_particle(particle_t p);
      result_t r;
      longint  dt, grav, drag_dt, factor, acc, half, np, vg;
      longint  p_in[3], v_in[3], wind[3], p_out[3], v_out[3];
      bit      windy;
      r = '0;
      // expired particles come back zeroed
      if (p.age_us > p.life_us) return r;
      dt = longint'({48'd0, settings.frame_delta});
      grav = -longint'(settings.gravity_accel);
      drag_dt = round_shift(longint'({32'd0, settings.drag_coeff}) * dt, DT_FRAC);
      factor = clamp32((longint'(1) << Q_FRAC) - drag_dt);
      windy = p.age_us < settings.wind_duration;
      p_in[0] = p.pos_x;
      p_in[1] = p.pos_y;
      p_in[2] = p.pos_z;
      v_in[0] = p.vel_x;
      v_in[1] = p.vel_y;
      v_in[2] = p.vel_z;
      wind[0] = settings.wind_x;
      wind[1] = settings.wind_y;
      wind[2] = settings.wind_z;
      for (int i = 0; i < 3; i++) begin
        // gravity only pulls on -Y
        acc = (i == 1) ? grav : 0;
        half = round_shift(acc * dt, DT_FRAC + 1);
        np = p_in[i] + round_shift((v_in[i] + half) * dt, DT_FRAC);
        if (windy) np -= round_shift(wind[i] * dt, DT_FRAC);
        p_out[i] = clamp32(np);
        vg = clamp32(v_in[i] + round_shift(acc * dt, DT_FRAC));
        v_out[i] = clamp32(round_shift(vg * factor, Q_FRAC));
      end
      r.new_pos_x = 32'(p_out[0]);
      r.new_pos_y = 32'(p_out[1]);
      r.new_pos_z = 32'(p_out[2]);
      r.new_vel_x = 32'(v_out[0]);
      r.new_vel_y = 32'(v_out[1]);
      r.new_vel_z = 32'(v_out[2]);
      r.alive = 1'b1;
      return r;
    endfunction

    function void note_particle(particle_t p);
      pending_moves.push_back(advance_particle(p));
    endfunction

    function int outstanding();
      return pending_moves.size();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Compare one result transaction with the oldest prediction
    task check_result(result_t r);
      result_t want;
      if (pending_moves.size() == 0) begin
        report_mismatch("result with no particle outstanding");
        return;
      end
      want = pending_moves.pop_front();
      check_field("new_pos_x", r.new_pos_x, want.new_pos_x);
      check_field("new_pos_y", r.new_pos_y, want.new_pos_y);
      check_field("new_pos_z", r.new_pos_z, want.new_pos_z);
      check_field("new_vel_x", r.new_vel_x, want.new_vel_x);
      check_field("new_vel_y", r.new_vel_y, want.new_vel_y);
      check_field("new_vel_z", r.new_vel_z, want.new_vel_z);
      check_field("alive", {31'd0, r.alive}, {31'd0, want.alive});
    endtask
  endclass

endpackage

// ===== dv/tb_particle_motion_step.sv =====
// Testbench top for the particle motion step: stimulus, handshake drivers and monitors.
module tb_particle_motion_step;
  timeunit 1ns;
  timeprecision 1ps;

  import pms_pkg::*;
  import motion_check_pkg::*;

  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 88;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  particle_valid = 1'b0;
  logic                  particle_stall;
  particle_t             particle = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  bit hold_req = 1'b0;

  motion_checker chk = new();

  particle_motion_step i_dut (
    .clk(clk),
    .rst(rst),
    .particle_valid(particle_valid),
    .particle_stall(particle_stall),
    .particle(particle),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Monitors: config writes, accepted particles, accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) chk.write_reg(cfg_reg_e'(cfg_index), cfg_data);
      if (particle_valid && !particle_stall) chk.note_particle(particle);
      if (result_valid && !result_stall) chk.check_result(result);
    end
  end

  // Result side: long hold-off on request, else random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Safety net against a hung pipe
  initial begin
    #5ms;
    $display("particle_motion_step regression: fail");
    $finish;
  end

  // One particle transaction, then maybe a gap; called right after a rising edge
  task automatic send_particle(particle_t p);
    particle <= p;
    particle_valid <= 1'b1;
    do @(posedge clk); while (particle_stall);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      particle_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Wait until every prediction is matched, then let the pipe settle
  task automatic drain_and_settle();
    particle_valid <= 1'b0;
    // wait for a clock edge so the monitor has logged the last accepted particle
    @(posedge clk);
    while (chk.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_beat(cfg_reg_e idx, logic [31:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all registers back to back, valid held high throughout
  task automatic program_regs(cfg_t c);
    cfg_valid <= 1'b1;
    cfg_beat(CFG_GRAVITY, c.gravity_accel);
    cfg_beat(CFG_DRAG, c.drag_coeff);
    cfg_beat(CFG_DT, {16'd0, c.frame_delta});
    cfg_beat(CFG_WIND_X, c.wind_x);
    cfg_beat(CFG_WIND_Y, c.wind_y);
    cfg_beat(CFG_WIND_Z, c.wind_z);
    cfg_beat(CFG_WIND_DUR, c.wind_duration);
    cfg_valid <= 1'b0;
  endtask

  function automatic particle_t mk(input s32_t px, py, pz, vx, vy, vz,
                                   input logic [31:0] age, life);
    particle_t p;
    p.pos_x = px;
    p.pos_y = py;
    p.pos_z = pz;
    p.vel_x = vx;
    p.vel_y = vy;
    p.vel_z = vz;
    p.age_us = age;
    p.life_us = life;
    return p;
  endfunction

  function automatic logic [31:0] extreme_word();
    case ($urandom_range(0, 3))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      default: return 32'hffffffff;
    endcase
  endfunction

  // Mostly modest positions and velocities, some full range and extremes
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return extreme_word();
      1, 2, 3: return $urandom;
      default: return $urandom_range(0, 1 << 25) - (1 << 24);
    endcase
  endfunction

  function automatic particle_t rand_particle();
    particle_t   p;
    logic [31:0] dur;
    p.pos_x = rand_coord();
    p.pos_y = rand_coord();
    p.pos_z = rand_coord();
    p.vel_x = rand_coord();
    p.vel_y = rand_coord();
    p.vel_z = rand_coord();
    dur = chk.settings.wind_duration;
    case ($urandom_range(0, 9))
      0: begin
        p.life_us = $urandom;
        p.age_us = $urandom;
      end
      1: begin
        p.life_us = $urandom;
        p.age_us = p.life_us;
      end
      2: begin
        // just expired
        p.life_us = $urandom_range(0, 32'hfffffffe);
        p.age_us = p.life_us + 1;
      end
      3: begin
        // age right at the wind cutoff
        p.life_us = 32'hffffffff;
        p.age_us = dur - $urandom_range(0, 1);
      end
      default: begin
        p.life_us = $urandom_range(0, 5_000_000);
        p.age_us = $urandom_range(0, p.life_us);
      end
    endcase
    return p;
  endfunction

  function automatic cfg_t rand_setting();
    cfg_t c;
    case ($urandom_range(0, 3))
      0: begin
        // plausible physics
        c.gravity_accel = $urandom_range(0, 40 << 16) - (20 << 16);
        c.drag_coeff = $urandom_range(0, 4 << 16);
        c.frame_delta = 16'($urandom_range(1, 16'h1000));
        c.wind_x = $urandom_range(0, 4 << 16) - (2 << 16);
        c.wind_y = $urandom_range(0, 4 << 16) - (2 << 16);
        c.wind_z = $urandom_range(0, 4 << 16) - (2 << 16);
        c.wind_duration = $urandom_range(0, 3_000_000);
      end
      1: begin
        c.gravity_accel = $urandom;
        c.drag_coeff = $urandom;
        c.frame_delta = 16'($urandom);
        c.wind_x = $urandom;
        c.wind_y = $urandom;
        c.wind_z = $urandom;
        c.wind_duration = $urandom;
      end
      2: begin
        c.gravity_accel = extreme_word();
        c.drag_coeff = extreme_word();
        c.frame_delta = 16'(extreme_word());
        c.wind_x = extreme_word();
        c.wind_y = extreme_word();
        c.wind_z = extreme_word();
        c.wind_duration = extreme_word();
      end
      default: begin
        c.gravity_accel = $urandom;
        c.drag_coeff = $urandom_range(0, 1 << 20);
        c.frame_delta = 16'($urandom_range(0, 255));
        c.wind_x = $urandom;
        c.wind_y = $urandom;
        c.wind_z = $urandom;
        c.wind_duration = $urandom_range(0, 5_000_000);
      end
    endcase
    return c;
  endfunction

  // Main sequence
  initial begin
    cfg_t setting;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    rx_idle_on = 1'b1;

    // reset config: dt is zero, nothing should move
    send_particle(mk(32'h12345678, 32'h9abcdef0, 32'h0fedcba9, 32'h00010000,
                     32'hfff00000, 32'h7fffffff, 3, 4));
    send_particle(mk(32'h7fffffff, 32'h80000000, 0, 32'h80000000, 32'h7fffffff, 0, 0, 0));
    drain_and_settle();

    // typical frame: 9.8 gravity, drag 0.5, 1/60 s, wind for one second
    setting.gravity_accel = 32'h0009cccc;
    setting.drag_coeff = 32'h00008000;
    setting.frame_delta = 16'h0444;
    setting.wind_x = 32'h00020000;
    setting.wind_y = 32'hffff0000;
    setting.wind_z = 32'h00008000;
    setting.wind_duration = 1_000_000;
    program_regs(setting);
    send_particle(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send_particle(mk(32'h10000, 32'hffff0000, 32'h20000, 32'h10000, 32'h50000, 32'hfffd0000,
                     999_999, 2_000_000));
    send_particle(mk(32'h10000, 32'hffff0000, 32'h20000, 32'h10000, 32'h50000, 32'hfffd0000,
                     1_000_000, 2_000_000));
    send_particle(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h7fffffff, 5, 5));
    send_particle(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h80000000, 5, 6));
    send_particle(mk(32'h7fffffff, 32'h80000000, 0, 32'h80000000, 32'h7fffffff, 32'hffffffff,
                     0, 32'hffffffff));
    send_particle(mk(1, 2, 3, 4, 5, 6, 1, 0));
    send_particle(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h7fffffff, 32'hffffffff, 32'hfffffffe));
    send_particle(mk(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                     32'hffffffff, 32'hffffffff, 32'hffffffff));
    drain_and_settle();

    // maximum gravity, drag, step and wind duration: drag factor saturates negative
    setting.gravity_accel = 32'h7fffffff;
    setting.drag_coeff = 32'hffffffff;
    setting.frame_delta = 16'hffff;
    setting.wind_x = 32'h80000000;
    setting.wind_y = 32'h7fffffff;
    setting.wind_z = 32'h80000000;
    setting.wind_duration = 32'hffffffff;
    program_regs(setting);
    send_particle(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send_particle(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h7fffffff, 0, 32'hffffffff));
    send_particle(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h80000000, 32'hfffffffe, 32'hffffffff));
    send_particle(mk(1, 1, 1, 1, 1, 1, 32'hffffffff, 32'hffffffff));
    drain_and_settle();

    // most negative gravity, no drag, full step
    setting.gravity_accel = 32'h80000000;
    setting.drag_coeff = 32'h0;
    setting.frame_delta = 16'hffff;
    setting.wind_x = 32'h7fffffff;
    setting.wind_y = 32'hffffffff;
    setting.wind_z = 32'h00000001;
    setting.wind_duration = 32'hffffffff;
    program_regs(setting);
    send_particle(mk(0, 0, 0, 0, 0, 0, 7, 100));
    send_particle(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h7fffffff, 0, 1));
    send_particle(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h80000000, 0, 1));
    send_particle(mk(32'h00018000, 32'hfff7ffff, 32'h55555555, 32'haaaaaaaa, 32'h00008000,
                     32'hffff8000, 100, 100));

    // random phases, one config each; pause for all results between them
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_and_settle();
      program_regs(rand_setting());
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      if (ph == 3) begin
        // receiver holds off while the sender keeps offering back to back
        tx_idle_on = 1'b0;
        hold_req = 1'b1;
      end
      if (ph == PHASES - 1) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      repeat (PHASE_ITEMS) send_particle(rand_particle());
    end
    drain_and_settle();

    if (chk.mismatches == 0) begin
      $display("particle_motion_step regression: pass");
    end else begin
      $display("particle_motion_step regression: fail");
    end
    $finish;
  end

endmodule

// ===== particle_motion_step.f =====
+incdir+rtl
rtl/pms_pkg.sv
rtl/pms_cfg_regs.sv
rtl/pms_front.sv
rtl/pms_back.sv
rtl/particle_motion_step.sv
dv/motion_check_pkg.sv
dv/tb_particle_motion_step.sv
